/* hdl/assert_macros.svh */
// Assertion macros used by the run queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rrq_pkg.sv */
// Shared types and codes of the round robin run queue.
package rrq_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SELECT = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_HEAD   = 2'd0,
		RD_CURSOR = 2'd1,
		RD_NEXT   = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE        = 2'd0,
		WR_TAIL_ID     = 2'd1,
		WR_TAIL_DATA   = 2'd2,
		WR_CURSOR_DATA = 2'd3
	} wr_sel_t;

	typedef struct packed {
		logic    take_item;
		logic    rd_en;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    head_adv;
		logic    count_inc;
		logic    count_dec;
		logic    cur_init;
		logic    cur_step;
		logic    chosen_load;
		logic    res_load;
		status_t res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic k_at_end;
		logic k1_at_end;
		logic hit;
		logic out_free;
	} dp_stat_t;

endpackage

/* hdl/rrq_ram.sv */
// Generic single write port, single read port RAM with registered read.
module rrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/rrq_datapath.sv */
// Datapath of the run queue: circular entry store, pointers, compare and result register.
module rrq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrq_pkg::dp_cmd_t               cmd,
	output rrq_pkg::dp_stat_t              stat,
	input  logic [ID_WIDTH-1:0]            in_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rrq_pkg::status_t               out_status,
	output logic [ID_WIDTH-1:0]            out_task,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] out_count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [ID_WIDTH-1:0] id_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [PTR_W-1:0]    cursor_q;
	logic [CNT_W-1:0]    k_q;
	logic [ID_WIDTH-1:0] chosen_q;
	logic                out_valid_q;
	rrq_pkg::status_t    res_status_q;
	logic [ID_WIDTH-1:0] res_task_q;
	logic [CNT_W-1:0]    res_count_q;

	logic [SUM_W-1:0]    tail_sum;
	logic [PTR_W-1:0]    tail_ptr;
	logic [PTR_W-1:0]    cursor_nxt;
	logic [PTR_W-1:0]    head_nxt;
	logic [PTR_W-1:0]    rd_addr;
	logic [PTR_W-1:0]    wr_addr;
	logic [ID_WIDTH-1:0] wr_data;
	logic                wr_en;
	logic [ID_WIDTH-1:0] rd_data;
	logic [SUM_W-1:0]    k_plus1;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_ptr   = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
	assign cursor_nxt = ptr_inc(cursor_q);
	assign head_nxt   = ptr_inc(head_q);
	assign k_plus1    = SUM_W'(k_q) + SUM_W'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			rrq_pkg::RD_HEAD:   rd_addr = head_q;
			rrq_pkg::RD_CURSOR: rd_addr = cursor_q;
			rrq_pkg::RD_NEXT:   rd_addr = cursor_nxt;
			default:            rd_addr = head_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = tail_ptr;
		wr_data = id_q;
		unique case (cmd.wr_sel)
			rrq_pkg::WR_NONE:        wr_en = 1'b0;
			rrq_pkg::WR_TAIL_ID:     wr_data = id_q;
			rrq_pkg::WR_TAIL_DATA:   wr_data = rd_data;
			rrq_pkg::WR_CURSOR_DATA: begin
				wr_addr = cursor_q;
				wr_data = rd_data;
			end
			default:                 wr_en = 1'b0;
		endcase
	end

	rrq_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.head_adv) begin
				head_q <= head_nxt;
			end
			if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.cur_init) begin
				cursor_q <= head_q;
				k_q      <= '0;
			end else if (cmd.cur_step) begin
				cursor_q <= cursor_nxt;
				k_q      <= k_q + 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			id_q     <= in_id;
			chosen_q <= '0;
		end else if (cmd.chosen_load) begin
			chosen_q <= rd_data;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_task_q   <= chosen_q;
			res_count_q  <= count_q;
		end
	end

	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.k_at_end   = (k_q == count_q);
	assign stat.k1_at_end  = (k_plus1 == SUM_W'(count_q));
	assign stat.hit        = (rd_data == id_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = res_status_q;
	assign out_task   = res_task_q;
	assign out_count  = res_count_q;

endmodule

/* hdl/rrq_ctrl.sv */
// Controller state machine of the run queue.
module rrq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rrq_pkg::op_t      mode,
	input  rrq_pkg::dp_stat_t stat,
	output rrq_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_SEL_RD,
		S_SEL_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SH_RD,
		S_SH_WR,
		S_FINISH
	} state_t;

	state_t           state_q;
	state_t           state_nxt;
	rrq_pkg::status_t code_q;
	rrq_pkg::status_t code_nxt;

	always_comb begin
		state_nxt      = state_q;
		code_nxt       = code_q;
		cmd            = '0;
		cmd.res_status = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					code_nxt      = rrq_pkg::ST_OK;
					unique case (mode)
						rrq_pkg::OP_ADD:    state_nxt = S_ADD;
						rrq_pkg::OP_REMOVE: begin
							cmd.cur_init = 1'b1;
							state_nxt    = S_SRCH_RD;
						end
						rrq_pkg::OP_SELECT: state_nxt = S_SEL_RD;
						rrq_pkg::OP_NOP:    state_nxt = S_FINISH;
						default:            state_nxt = S_FINISH;
					endcase
				end
			end
			S_ADD: begin
				if (stat.count_full) begin
					code_nxt = rrq_pkg::ST_FULL;
				end else begin
					cmd.wr_sel    = rrq_pkg::WR_TAIL_ID;
					cmd.count_inc = 1'b1;
				end
				state_nxt = S_FINISH;
			end
			S_SEL_RD: begin
				if (stat.count_zero) begin
					code_nxt  = rrq_pkg::ST_EMPTY;
					state_nxt = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rrq_pkg::RD_HEAD;
					state_nxt  = S_SEL_WR;
				end
			end
			S_SEL_WR: begin
				cmd.wr_sel      = rrq_pkg::WR_TAIL_DATA;
				cmd.head_adv    = 1'b1;
				cmd.chosen_load = 1'b1;
				state_nxt       = S_FINISH;
			end
			S_SRCH_RD: begin
				if (stat.k_at_end) begin
					code_nxt  = rrq_pkg::ST_NOT_FOUND;
					state_nxt = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rrq_pkg::RD_CURSOR;
					state_nxt  = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (stat.hit) begin
					state_nxt = S_SH_RD;
				end else begin
					cmd.cur_step = 1'b1;
					state_nxt    = S_SRCH_RD;
				end
			end
			S_SH_RD: begin
				if (stat.k1_at_end) begin
					cmd.count_dec = 1'b1;
					state_nxt     = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = rrq_pkg::RD_NEXT;
					state_nxt  = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr_sel   = rrq_pkg::WR_CURSOR_DATA;
				cmd.cur_step = 1'b1;
				state_nxt    = S_SH_RD;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= rrq_pkg::ST_OK;
		end else begin
			state_q <= state_nxt;
			code_q  <= code_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

/* hdl/round_robin_run_queue.sv */
// Top level of the round robin run queue: controller, datapath and ports.
//
//  channel  | direction | tuser          | tdata (low bit up)
//  s_*      | in        | [1:0] mode     | task_id, zero pad to bytes
//  m_*      | out       | [1:0] status   | next_task, queue_count, zero pad to bytes
//
// One beat in gives one beat out. Remove runs a search and then a shift, and
// each step of either reads one entry through the single read port of the entry
// RAM before it compares that entry or writes it back.
// Reset clears count, head and handshake state; entry RAM contents are not cleared.
// A new beat is taken while a finished result still waits on the m_* side.
`include "assert_macros.svh"
module round_robin_run_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [1:0] s_tuser,                                 // mode
	input  logic [((ID_WIDTH+7)/8)*8-1:0] s_tdata,              // task_id
	output logic m_tvalid,
	input  logic m_tready,
	output logic [1:0] m_tuser,                                 // status
	output logic [((ID_WIDTH+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata // next_task, queue_count
);

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DW = ((ID_WIDTH + CNT_W + 7) / 8) * 8;

	rrq_pkg::dp_cmd_t  cmd;
	rrq_pkg::dp_stat_t stat;
	rrq_pkg::status_t  out_status;
	logic [ID_WIDTH-1:0] out_task;
	logic [CNT_W-1:0]    out_count;
	logic                sel_empty;
	logic                add_full;

	rrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.mode     (rrq_pkg::op_t'(s_tuser)),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_id      (s_tdata[ID_WIDTH-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_task   (out_task),
		.out_count  (out_count)
	);

	assign m_tuser = out_status;
	assign m_tdata = OUT_DW'({out_count, out_task});

	assign sel_empty = m_tvalid && (out_status == rrq_pkg::ST_EMPTY);
	assign add_full  = m_tvalid && (out_status == rrq_pkg::ST_FULL);

	`ASSERT_NEXT(a_busy_after_beat, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, m_tvalid, out_count <= CNT_W'(QUEUE_DEPTH))
	`ASSERT_IMPLIES(a_empty_result, clk, arst_n, sel_empty, out_task == '0 && out_count == '0)
	`ASSERT_IMPLIES(a_full_result, clk, arst_n, add_full, out_count == CNT_W'(QUEUE_DEPTH))

endmodule
